// File: sv/ntip_pkg.sv
package ntip_pkg;

    localparam logic [4:0] LEFT_PART_LIMIT = 5'd19;
    localparam logic [4:0] LEN_MAX         = 5'd31;

    // front queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // base_code values
    localparam logic [2:0] BC_AUTO = 3'd0;
    localparam logic [2:0] BC_BIN  = 3'd1;
    localparam logic [2:0] BC_OCT  = 3'd2;
    localparam logic [2:0] BC_DEC  = 3'd3;
    localparam logic [2:0] BC_HEX  = 3'd4;

    // active base; zero while an auto prefix is undecided
    localparam logic [4:0] BASE_AUTO = 5'd0;
    localparam logic [4:0] BASE_BIN  = 5'd2;
    localparam logic [4:0] BASE_OCT  = 5'd8;
    localparam logic [4:0] BASE_DEC  = 5'd10;
    localparam logic [4:0] BASE_HEX  = 5'd16;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_F  = 8'h66;
    localparam logic [7:0] CH_LO_N  = 8'h6E;
    localparam logic [7:0] CH_LO_O  = 8'h6F;
    localparam logic [7:0] CH_LO_T  = 8'h74;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    typedef enum logic [2:0] {
        K_PLAIN,
        K_DOT,
        K_LOW_X,
        K_UP_X,
        K_DEC_PFX,
        K_OCT_PFX
    } t_kind;

    // prefix window
    typedef enum logic [1:0] {
        WIN_NONE,
        WIN_OUTER,
        WIN_LEFT,
        WIN_RIGHT
    } t_win;

    typedef struct packed {
        logic [7:0] ch;
        logic [2:0] base_code;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] value;
        logic        ok;
    } t_out;

    // classified character
    typedef struct packed {
        t_kind      kind;
        logic       dig_ok;
        logic [3:0] dig;
        logic [2:0] base_code;
        logic       last;
    } t_item;

endpackage

// File: sv/ntip_front.sv
module ntip_front
    import ntip_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_in   i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    t_item                r_q [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  r_wr;
    logic [QUEUE_AW-1:0]  r_rd;
    logic [QUEUE_AW:0]    r_cnt;
    logic [QUEUE_AW-1:0]  n_wr;
    logic [QUEUE_AW-1:0]  n_rd;
    logic [QUEUE_AW:0]    n_cnt;
    t_item                cls;
    logic                 wr_en;
    logic                 rd_en;

    always_comb begin
        cls           = '0;
        cls.kind      = K_PLAIN;
        cls.base_code = i_item.base_code;
        cls.last      = i_item.last;
        if (i_item.ch >= CH_ZERO && i_item.ch <= CH_NINE) begin
            cls.dig_ok = 1'b1;
            cls.dig    = 4'(i_item.ch - CH_ZERO);
        end else if (i_item.ch >= CH_LO_A && i_item.ch <= CH_LO_F) begin
            cls.dig_ok = 1'b1;
            cls.dig    = 4'(i_item.ch - CH_LO_A + 8'd10);
        end else if (i_item.ch >= CH_UP_A && i_item.ch <= CH_UP_F) begin
            cls.dig_ok = 1'b1;
            cls.dig    = 4'(i_item.ch - CH_UP_A + 8'd10);
        end
        unique case (i_item.ch)
            CH_DOT:          cls.kind = K_DOT;
            CH_LO_X:         cls.kind = K_LOW_X;
            CH_UP_X:         cls.kind = K_UP_X;
            CH_LO_T, CH_LO_N: cls.kind = K_DEC_PFX;
            CH_LO_O:         cls.kind = K_OCT_PFX;
            default:         cls.kind = K_PLAIN;
        endcase
    end

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_q[r_rd];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_take && o_valid;

    always_comb begin
        n_wr  = r_wr + QUEUE_AW'(wr_en);
        n_rd  = r_rd + QUEUE_AW'(rd_en);
        n_cnt = r_cnt + (QUEUE_AW+1)'(wr_en) - (QUEUE_AW+1)'(rd_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_q[r_wr] <= cls;
        end
    end

endmodule

// File: sv/ntip_back.sv
module ntip_back
    import ntip_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    output logic  o_take,
    output logic  o_empty,
    input  logic  i_pop,
    output t_out  o_result
);

    function automatic logic [4:0] decode_base(input logic [2:0] code);
        case (code)
            BC_AUTO: decode_base = BASE_AUTO;
            BC_BIN:  decode_base = BASE_BIN;
            BC_OCT:  decode_base = BASE_OCT;
            BC_HEX:  decode_base = BASE_HEX;
            default: decode_base = BASE_DEC;
        endcase
    endfunction

    function automatic logic [31:0] scale(input logic [31:0] acc, input logic [4:0] base);
        case (base)
            BASE_BIN: scale = acc << 1;
            BASE_OCT: scale = acc << 3;
            BASE_HEX: scale = acc << 4;
            default:  scale = (acc << 3) + (acc << 1);
        endcase
    endfunction

    // numeral state
    logic        r_first, n_first;
    logic [4:0]  r_base, n_base;
    t_win        r_win, n_win;
    logic        r_zero, n_zero;
    logic        r_fail, n_fail;
    logic        r_dot, n_dot;
    logic        r_need, n_need;
    logic        r_long, n_long;
    logic [4:0]  r_len, n_len;
    logic [31:0] r_plain, n_plain;
    logic [31:0] r_left, n_left;
    logic [31:0] r_frac, n_frac;

    // result queue
    t_out        r_oq [2];
    logic        r_owr, r_ord;
    logic [1:0]  r_ocnt;
    logic        o_push, o_pop;
    t_out        res;

    logic        do_take;
    logic        do_count;
    logic        is_zero;
    logic        is_x;
    t_win        win0;

    assign o_take  = i_valid && (r_ocnt != 2'd2);
    assign is_zero = i_item.dig_ok && (i_item.dig == 4'd0);
    assign is_x    = (i_item.kind == K_LOW_X) || (i_item.kind == K_UP_X);

    always_comb begin
        n_first  = r_first;
        n_base   = r_first ? decode_base(i_item.base_code) : r_base;
        win0     = r_first ? WIN_OUTER : r_win;
        n_win    = win0;
        n_zero   = r_zero;
        n_fail   = r_fail;
        n_dot    = r_dot;
        n_need   = r_need;
        n_long   = r_long;
        n_len    = r_len;
        n_plain  = r_plain;
        n_left   = r_left;
        n_frac   = r_frac;
        do_take  = 1'b0;
        do_count = 1'b0;
        res      = '0;
        o_push   = 1'b0;

        if (!r_fail) begin
            n_zero = 1'b0;
            if (win0 != WIN_NONE && r_zero) begin
                n_win = WIN_NONE;
                if (n_base == BASE_AUTO) begin
                    case (i_item.kind) inside
                        K_LOW_X, K_DEC_PFX, K_OCT_PFX: begin
                            n_base = (i_item.kind == K_LOW_X)   ? BASE_HEX :
                                     (i_item.kind == K_OCT_PFX) ? BASE_OCT : BASE_DEC;
                            n_len  = '0;
                            n_long = 1'b0;
                            n_win  = WIN_OUTER;
                        end
                        K_UP_X: begin
                            n_base = BASE_HEX;
                            n_len  = '0;
                            n_long = 1'b0;
                            n_win  = WIN_LEFT;
                        end
                        default: begin
                            n_base  = BASE_DEC;
                            do_take = 1'b1;
                        end
                    endcase
                end else if (is_x) begin
                    if (win0 == WIN_OUTER) begin
                        n_base = BASE_HEX;
                        n_len  = '0;
                        n_long = 1'b0;
                        n_win  = WIN_LEFT;
                    end else if (win0 == WIN_LEFT) begin
                        do_count = 1'b1;
                        n_need   = 1'b1;
                    end
                end else begin
                    do_take = 1'b1;
                end
            end else if (win0 != WIN_NONE) begin
                if (is_zero) begin
                    n_zero = 1'b1;
                    if (n_base == BASE_AUTO) begin
                        do_count = 1'b1;
                    end else begin
                        do_take = 1'b1;
                    end
                end else begin
                    n_win = WIN_NONE;
                    if (n_base == BASE_AUTO) begin
                        n_base = BASE_DEC;
                    end
                    do_take = 1'b1;
                end
            end else begin
                do_take = 1'b1;
            end

            if (do_take) begin
                if (i_item.kind == K_DOT) begin
                    if (n_base != BASE_HEX || n_dot) begin
                        n_fail = 1'b1;
                    end else if (n_long || n_len > LEFT_PART_LIMIT) begin
                        n_fail = 1'b1;
                    end else begin
                        n_left = n_plain;
                        n_frac = '0;
                        n_dot  = 1'b1;
                        n_win  = WIN_RIGHT;
                    end
                end else if (!i_item.dig_ok || {1'b0, i_item.dig} >= n_base) begin
                    n_fail = 1'b1;
                end else if (n_dot) begin
                    n_frac = (n_frac << 4) + 32'(i_item.dig);
                end else begin
                    n_plain  = scale(n_plain, n_base) + 32'(i_item.dig);
                    do_count = 1'b1;
                end
            end

            if (do_count) begin
                if (n_len >= LEN_MAX) begin
                    n_long = 1'b1;
                end else begin
                    n_len = n_len + 5'd1;
                end
            end
        end

        n_first = 1'b0;
        if (i_item.last) begin
            o_push   = 1'b1;
            res.ok   = !n_fail && !(n_need && !n_dot);
            res.value = res.ok ? (n_dot ? ((n_left << 16) + n_frac) : n_plain) : '0;
            n_first  = 1'b1;
            n_base   = BASE_DEC;
            n_win    = WIN_NONE;
            n_zero   = 1'b0;
            n_fail   = 1'b0;
            n_dot    = 1'b0;
            n_need   = 1'b0;
            n_long   = 1'b0;
            n_len    = '0;
            n_plain  = '0;
            n_left   = '0;
            n_frac   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_base  <= BASE_DEC;
            r_win   <= WIN_NONE;
            r_zero  <= 1'b0;
            r_fail  <= 1'b0;
            r_dot   <= 1'b0;
            r_need  <= 1'b0;
            r_long  <= 1'b0;
            r_len   <= '0;
            r_plain <= '0;
            r_left  <= '0;
            r_frac  <= '0;
        end else if (o_take) begin
            r_first <= n_first;
            r_base  <= n_base;
            r_win   <= n_win;
            r_zero  <= n_zero;
            r_fail  <= n_fail;
            r_dot   <= n_dot;
            r_need  <= n_need;
            r_long  <= n_long;
            r_len   <= n_len;
            r_plain <= n_plain;
            r_left  <= n_left;
            r_frac  <= n_frac;
        end
    end

    // two-entry result queue so a stalled reader does not stop the parser at once
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_pop    = i_pop && !o_empty;
    assign o_result = r_oq[r_ord];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owr  <= 1'b0;
            r_ord  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            r_owr  <= r_owr ^ (o_take && o_push);
            r_ord  <= r_ord ^ o_pop;
            r_ocnt <= r_ocnt + 2'(o_take && o_push) - 2'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && o_push) begin
            r_oq[r_owr] <= res;
        end
    end

endmodule

// File: sv/numeral_to_integer_parser.sv
// ASCII numeral parser: one character per beat in, one {value, ok} beat out at
// each character flagged last. The parser takes one character every cycle
// that the result queue is not full; the single shift-and-add per character
// sets that figure. A character sits in a four-entry input queue before the
// parser works on it, and a result waits in the result queue before it shows
// on the output side. The parser stalls in every cycle that the two-entry
// result queue holds two results, even one in which pop drains a result;
// full rises only after four characters have piled up behind such stalls.
module numeral_to_integer_parser
    import ntip_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic push,
    output logic full,
    input  t_in  i_item,
    output logic empty,
    input  logic pop,
    output t_out o_result
);

    logic  q_valid;
    t_item q_item;
    logic  q_take;

    ntip_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    ntip_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_take   (q_take),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_result (o_result)
    );

endmodule

// File: sv/ntip_checker.sv
module ntip_checker
    import ntip_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic push,
    input logic full,
    input t_in  i_item,
    input logic empty,
    input logic pop,
    input t_out o_result
);

    // both queues come out of reset drained
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a waiting result holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_result))
        else $error("result changed while stalled");

    // a failed numeral always reads as zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_result.ok |-> o_result.value == 32'd0)
        else $error("failed result with nonzero value");

endmodule

bind numeral_to_integer_parser ntip_checker u_ntip_checker (.*);

// File: bench/tb.sv
module tb;
    import ntip_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 4;
    localparam int CYCLE_LIMIT = 500000;
    localparam int RANDOM_CHARS = 1600;
    localparam int DRAIN_EVERY  = 40;

    // base codes with no base of their own; they parse as decimal
    localparam logic [2:0] BC_SPARE_5 = 3'd5;
    localparam logic [2:0] BC_SPARE_6 = 3'd6;
    localparam logic [2:0] BC_SPARE_7 = 3'd7;

    typedef struct packed {
        t_in  item;
        logic drain;    // hold this beat until every parsed value has come back
    } t_char_req;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_in  i_item  = '0;
    logic full;
    logic empty;
    t_out o_result;

    numeral_to_integer_parser u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_char_req  char_stream[$];
    logic [7:0] numeral_text[$];
    t_out       parsed_values[$];
    t_out       want;
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         char_taken  = 1'b0;
    int         burst_left  = 4;
    int         gap_left    = 0;
    int         stall_left  = 0;
    int         rx_cycle    = 0;
    int         rx_mode     = 0;
    bit         rx_take;

    // parser state as the block should hold it
    logic [4:0]  char_pos;
    logic [4:0]  cur_base;
    logic [31:0] plain_acc;
    logic [31:0] left_acc;
    logic [31:0] frac_acc;
    logic [4:0]  int_len;
    logic        failed;
    logic        zero_seen;
    t_win        win;
    logic        dot_seen;
    logic        need_dot;
    logic        int_too_long;

    task automatic clear_numeral();
        char_pos     = '0;
        cur_base     = BASE_DEC;
        plain_acc    = '0;
        left_acc     = '0;
        frac_acc     = '0;
        int_len      = '0;
        failed       = 1'b0;
        zero_seen    = 1'b0;
        win          = WIN_NONE;
        dot_seen     = 1'b0;
        need_dot     = 1'b0;
        int_too_long = 1'b0;
    endtask

    task automatic count_int_char();
        if (int_len >= LEN_MAX) begin
            int_too_long = 1'b1;
        end else begin
            int_len = int_len + 5'd1;
        end
    endtask

    task automatic clear_int_count();
        int_len      = '0;
        int_too_long = 1'b0;
    endtask

    task automatic accept_symbol(input logic [7:0] c);
        int unsigned d;
        if (c == CH_DOT) begin
            if (cur_base != BASE_HEX || dot_seen) begin
                failed = 1'b1;
            end else if (int_too_long || int_len > LEFT_PART_LIMIT) begin
                failed = 1'b1;
            end else begin
                left_acc = plain_acc;
                frac_acc = '0;
                dot_seen = 1'b1;
                win      = WIN_RIGHT;
            end
        end else begin
            if (c >= CH_ZERO && c <= CH_NINE) begin
                d = 32'(c - CH_ZERO);
            end else if (c >= CH_LO_A && c <= CH_LO_F) begin
                d = 32'(c - CH_LO_A) + 10;
            end else if (c >= CH_UP_A && c <= CH_UP_F) begin
                d = 32'(c - CH_UP_A) + 10;
            end else begin
                d = 99;
            end
            if (d >= cur_base) begin
                failed = 1'b1;
            end else if (dot_seen) begin
                frac_acc = frac_acc * 32'd16 + d;
            end else begin
                plain_acc = plain_acc * cur_base + d;
                count_int_char();
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        t_win w;
        logic z;
        w = win;
        z = zero_seen;
        zero_seen = 1'b0;
        if (w != WIN_NONE && z) begin
            // character right after a leading zero: prefix letter or plain digit
            win = WIN_NONE;
            if (cur_base == BASE_AUTO) begin
                if (c == CH_LO_X || c == CH_LO_T || c == CH_LO_N || c == CH_LO_O) begin
                    cur_base = (c == CH_LO_X) ? BASE_HEX : (c == CH_LO_O) ? BASE_OCT : BASE_DEC;
                    clear_int_count();
                    win = WIN_OUTER;
                end else if (c == CH_UP_X) begin
                    cur_base = BASE_HEX;
                    clear_int_count();
                    win = WIN_LEFT;
                end else begin
                    cur_base = BASE_DEC;
                    accept_symbol(c);
                end
            end else if (c == CH_LO_X || c == CH_UP_X) begin
                if (w == WIN_OUTER) begin
                    cur_base = BASE_HEX;
                    clear_int_count();
                    win = WIN_LEFT;
                end else if (w == WIN_LEFT) begin
                    // integer-part prefix: only legal if a dot follows
                    count_int_char();
                    need_dot = 1'b1;
                end
            end else begin
                accept_symbol(c);
            end
        end else if (w != WIN_NONE && c == CH_ZERO) begin
            zero_seen = 1'b1;
            if (cur_base == BASE_AUTO) begin
                count_int_char();
            end else begin
                accept_symbol(c);
            end
        end else begin
            if (w != WIN_NONE) begin
                win = WIN_NONE;
                if (cur_base == BASE_AUTO) begin
                    cur_base = BASE_DEC;
                end
            end
            accept_symbol(c);
        end
    endtask

    task automatic predict_char(input t_in it);
        t_out r;
        logic good;
        logic [31:0] v;
        if (char_pos == '0) begin
            case (it.base_code)
                BC_AUTO: cur_base = BASE_AUTO;
                BC_BIN:  cur_base = BASE_BIN;
                BC_OCT:  cur_base = BASE_OCT;
                BC_HEX:  cur_base = BASE_HEX;
                default: cur_base = BASE_DEC;
            endcase
            win = WIN_OUTER;
        end
        if (!failed) begin
            parse_char(it.ch);
        end
        if (char_pos < LEN_MAX) begin
            char_pos = char_pos + 5'd1;
        end
        if (it.last) begin
            good = !failed && !(need_dot && !dot_seen);
            v = dot_seen ? (left_acc << 16) + frac_acc : plain_acc;
            r.value = good ? v : '0;
            r.ok = good;
            parsed_values.push_back(r);
            clear_numeral();
        end
    endtask

    // ---------------- stimulus construction ----------------

    task automatic text_add(input string s);
        for (int i = 0; i < s.len(); i++) begin
            numeral_text.push_back(s[i]);
        end
    endtask

    task automatic add_hex_prefix();
        numeral_text.push_back(CH_ZERO);
        numeral_text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
    endtask

    function automatic logic [7:0] digit_char(input int unsigned d);
        if (d < 10) begin
            return 8'(CH_ZERO + d);
        end
        return 8'(($urandom_range(0, 1) ? CH_LO_A : CH_UP_A) + d - 10);
    endfunction

    task automatic add_digits(input int unsigned n, input int unsigned radix);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(0, 47) == 0) begin
                numeral_text.push_back(8'($urandom_range(0, 255)));
            end else begin
                numeral_text.push_back(digit_char($urandom_range(0, radix - 1)));
            end
        end
    endtask

    task automatic emit_numeral(input logic [2:0] code, input bit drain);
        t_char_req req;
        for (int i = 0; i < numeral_text.size(); i++) begin
            req.item.ch        = numeral_text[i];
            req.item.base_code = (i == 0) ? code : 3'($urandom_range(0, 7));
            req.item.last      = (i == numeral_text.size() - 1);
            req.drain          = drain && (i == 0);
            char_stream.push_back(req);
        end
        numeral_text.delete();
    endtask

    task automatic make_numeral(input bit drain);
        logic [2:0] code;
        int unsigned radix;
        int unsigned pick;
        int unsigned n_int;
        code = 3'($urandom_range(0, 7));
        radix = 10;
        if ($urandom_range(0, 15) == 0) begin
            // junk: random bytes mixed with prefix letters and dots
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 5))
                    0: numeral_text.push_back(CH_ZERO);
                    1: numeral_text.push_back(CH_LO_X);
                    2: numeral_text.push_back(CH_UP_X);
                    3: numeral_text.push_back(CH_DOT);
                    4: numeral_text.push_back($urandom_range(0, 1) ? CH_LO_T : CH_LO_N);
                    default: numeral_text.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end else begin
            case (code)
                BC_AUTO: begin
                    pick = $urandom_range(0, 5);
                    if (pick < 5) begin
                        numeral_text.push_back(CH_ZERO);
                        case (pick)
                            0: begin
                                numeral_text.push_back(CH_LO_X);
                                radix = 16;
                            end
                            1: numeral_text.push_back(CH_LO_T);
                            2: numeral_text.push_back(CH_LO_N);
                            3: begin
                                numeral_text.push_back(CH_LO_O);
                                radix = 8;
                            end
                            default: begin
                                numeral_text.push_back(CH_UP_X);
                                radix = 16;
                            end
                        endcase
                    end
                end
                BC_BIN:  radix = 2;
                BC_OCT:  radix = 8;
                BC_HEX:  radix = 16;
                default: radix = 10;
            endcase
            if ($urandom_range(0, 3) == 0) begin
                add_hex_prefix();
                radix = 16;
            end
            if (radix == 16 && $urandom_range(0, 5) == 0) begin
                add_hex_prefix();
            end
            pick = $urandom_range(0, 31);
            if (pick < 3) begin
                n_int = $urandom_range(17, 22);     // around the integer-part limit
            end else if (pick == 3) begin
                n_int = $urandom_range(30, 36);     // saturate the counters
            end else begin
                n_int = $urandom_range(0, 8);
            end
            add_digits(n_int, radix);
            if (radix == 16 ? $urandom_range(0, 2) != 0 : $urandom_range(0, 19) == 0) begin
                numeral_text.push_back(CH_DOT);
                if (radix == 16 && $urandom_range(0, 3) == 0) begin
                    add_hex_prefix();
                end
                add_digits($urandom_range(0, 8), radix);
                if ($urandom_range(0, 19) == 0) begin
                    numeral_text.push_back(CH_DOT);
                    add_digits($urandom_range(0, 2), radix);
                end
            end
        end
        if (numeral_text.size() == 0) begin
            add_digits(1, radix);
        end
        emit_numeral(code, drain);
    endtask

    // ---------------- sender ----------------

    always @(negedge i_clk) begin
        if (char_taken) begin
            burst_left = burst_left - 1;
            if (burst_left <= 0) begin
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 8);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
        if (!i_rst_n || char_stream.size() == 0) begin
            push <= 1'b0;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            push <= 1'b0;
        end else if (char_stream[0].drain && parsed_values.size() != 0) begin
            push <= 1'b0;
        end else begin
            push   <= 1'b1;
            i_item <= char_stream[0].item;
        end
    end

    // ---------------- receiver ----------------

    always @(negedge i_clk) begin
        rx_cycle = rx_cycle + 1;
        if (rx_cycle % 300 == 0) begin
            rx_mode = $urandom_range(0, 3);
        end
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rx_take = 1'b0;
        end else begin
            case (rx_mode)
                0: rx_take = 1'b1;
                1: rx_take = ($urandom_range(0, 2) != 0);
                2: begin
                    // long stalls back up both queues so full gets exercised
                    rx_take = 1'b1;
                    if ($urandom_range(0, 11) == 0) begin
                        stall_left = $urandom_range(8, 40);
                    end
                end
                default: rx_take = (rx_cycle % 5) < 2;
            endcase
        end
        pop <= i_rst_n && rx_take;
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        char_taken = 1'b0;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_char(i_item);
                void'(char_stream.pop_front());
                char_taken = 1'b1;
            end
            if (pop && !empty) begin
                if (parsed_values.size() == 0) begin
                    $error("result beat with nothing expected: value %h ok %b",
                           o_result.value, o_result.ok);
                    mismatches = mismatches + 1;
                end else begin
                    want = parsed_values.pop_front();
                    if (o_result.value !== want.value) begin
                        $error("value: expected %h, got %h", want.value, o_result.value);
                        mismatches = mismatches + 1;
                    end
                    if (o_result.ok !== want.ok) begin
                        $error("ok: expected %b, got %b", want.ok, o_result.ok);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL numeral_to_integer_parser");
            $finish;
        end
    end

    initial begin
        int numeral_no;
        clear_numeral();

        // directed numerals
        text_add("0x");    emit_numeral(BC_AUTO, 1'b0);     // prefix only
        text_add("0XA");   emit_numeral(BC_AUTO, 1'b0);
        text_add("0o");    emit_numeral(BC_AUTO, 1'b0);
        text_add("1.");    emit_numeral(BC_DEC, 1'b0);      // dot outside hex
        text_add("..");    emit_numeral(BC_HEX, 1'b0);      // second dot
        text_add("0x0x1"); emit_numeral(BC_HEX, 1'b0);      // inner prefix, no dot
        text_add("2");     emit_numeral(BC_BIN, 1'b0);      // digit too big
        numeral_text.push_back(8'h00);
        emit_numeral(BC_SPARE_7, 1'b0);
        numeral_text.push_back(8'hFF);
        emit_numeral(BC_SPARE_5, 1'b0);
        text_add("9");     emit_numeral(BC_SPARE_6, 1'b0);
        text_add("7");     emit_numeral(BC_OCT, 1'b0);

        numeral_no = 0;
        while (char_stream.size() < RANDOM_CHARS + 25) begin
            make_numeral(numeral_no % DRAIN_EVERY == DRAIN_EVERY / 2);
            numeral_no = numeral_no + 1;
        end

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (char_stream.size() != 0 || parsed_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS numeral_to_integer_parser");
        end else begin
            $display("FAIL numeral_to_integer_parser");
        end
        $finish;
    end

endmodule

// File: files.f
sv/ntip_pkg.sv
sv/ntip_front.sv
sv/ntip_back.sv
sv/numeral_to_integer_parser.sv
sv/ntip_checker.sv
bench/tb.sv
